// ===== rtl/lrt_pkg.sv =====
// Shared types, constants and helper functions for the logistic regression trainer.
// No dependencies; lrt_sigm and the top level refer to this package by scoped names.

package lrt_pkg;

    localparam int LRT_MAX_SAMPLES = 1024;
    localparam int LRT_SIG_ENTRIES = 256;

    localparam int X_W = 32;
    localparam int Y_W = 17;
    localparam int P_W = 17;

    localparam logic [15:0] LR_RESET     = 16'd655;
    localparam logic [15:0] EPOCHS_RESET = 16'd100;
    localparam logic [16:0] THRESH_RESET = 17'd32768;
    localparam logic [16:0] ONE_Q16      = 17'd65536;

    // sigmoid input span is -8.0 .. +8.0 in Q16.16
    localparam int Z_SPAN = 524288;
    localparam logic [63:0] NEG_E1_Q32 = 64'd1580030169;

    typedef enum logic [1:0] {
        CFG_LR     = 2'd0,
        CFG_EPOCHS = 2'd1,
        CFG_THRESH = 2'd2
    } t_cfg_idx;

    localparam logic OP_TRAIN   = 1'b0;
    localparam logic OP_PREDICT = 1'b1;
    localparam logic KIND_MODEL = 1'b0;
    localparam logic KIND_PRED  = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_FULL  = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Unsigned long division by shift and subtract; used only while building tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Exact sigmoid of a Q16.16 value, used only to build the lookup table.
    function automatic logic [16:0] sig_exact(input longint z);
        logic [63:0] t;
        logic [63:0] f;
        logic [63:0] k;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] s;
        longint sum;
        logic done;
        t = (z < 0) ? 64'(-z) : 64'(z);
        f = t & 64'hFFFF;
        k = t >> 16;
        sum = 64'sh1_0000_0000;
        term = 64'h1_0000_0000;
        done = 1'b0;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                term = udiv64((term * f) >> 16, 64'(n));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((n & 1) != 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > 64'sh1_0000_0000) begin
            sum = 64'sh1_0000_0000;
        end
        e = 64'(sum);
        for (int j = 0; j < 8; j++) begin
            if (64'(j) < k) begin
                e = (e * NEG_E1_Q32) >> 32;
            end
        end
        d = 64'h1_0000_0000 + e;
        s = udiv64(64'h1_0000_0000_0000 + (d >> 1), d);
        return (z < 0) ? 17'(64'd65536 - s) : 17'(s);
    endfunction

endpackage

// ===== rtl/lrt_mem.sv =====
// Sample store: single write port, single read port, registered read data.
// Depends on nothing; widths come from the instantiating module.

module lrt_mem #(
    parameter int AW = 10,
    parameter int DW = 49
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lrt_sigm.sv =====
// Three-stage interpolated sigmoid lookup over a constant table built at elaboration.
// Depends on lrt_pkg (sig_exact, udiv64, Z_SPAN); carries a side payload alongside.

module lrt_sigm #(
    parameter int ENTRIES = 256,
    parameter int SW      = 49
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_v,
    input  logic signed [48:0] i_z,
    input  logic [SW-1:0]      i_side,
    output logic               o_v,
    output logic [16:0]        o_p,
    output logic [SW-1:0]      o_side
);

    localparam int IW = $clog2(ENTRIES);
    localparam int UW = 20 + IW;
    localparam logic signed [48:0] ZHI = 49'(lrt_pkg::Z_SPAN);
    localparam logic signed [48:0] ZLO = -ZHI;

    typedef logic [16:0] t_tbl [ENTRIES];

    function automatic t_tbl f_build();
        t_tbl   t;
        longint off;
        for (int i = 0; i < ENTRIES; i++) begin
            off = longint'(lrt_pkg::udiv64(64'(longint'(1048576) * i), 64'(ENTRIES - 1)));
            t[i] = lrt_pkg::sig_exact(off - longint'(lrt_pkg::Z_SPAN));
        end
        return t;
    endfunction

    localparam t_tbl TBL = f_build();

    logic               r1_v, r2_v, r3_v;
    logic               r1_lo, r1_hi;
    logic [UW-1:0]      r1_u;
    logic [SW-1:0]      r1_side, r2_side, r3_side;
    logic signed [38:0] r2_prod;
    logic [16:0]        r2_t0;
    logic [16:0]        r3_p;

    logic [19:0]        zo;
    logic [IW-1:0]      idx, idx1;
    logic [19:0]        frac;
    logic [16:0]        t0, t1;
    logic               interp;
    logic signed [17:0] diff;
    logic signed [18:0] psum;

    // offset into 0 .. 2^20 - 1 by flipping bit 19; valid only when in range
    assign zo = i_z[19:0] ^ 20'h80000;

    always_comb begin
        idx    = r1_u[UW-1:20];
        idx1   = idx + 1'b1;
        frac   = r1_u[19:0];
        t0     = TBL[0];
        t1     = TBL[0];
        interp = 1'b0;
        if (r1_lo) begin
            t0 = TBL[0];
        end else if (r1_hi || idx >= IW'(ENTRIES - 1)) begin
            t0 = TBL[ENTRIES-1];
        end else begin
            t0     = TBL[idx];
            t1     = TBL[idx1];
            interp = 1'b1;
        end
        diff = interp ? ($signed({1'b0, t1}) - $signed({1'b0, t0})) : 18'sd0;
    end

    assign psum = $signed({2'b00, r2_t0}) + r2_prod[38:20];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        r1_lo   <= (i_z <= ZLO);
        r1_hi   <= (i_z >= ZHI);
        r1_u    <= UW'(zo) * UW'(ENTRIES - 1);
        r1_side <= i_side;
        r2_prod <= diff * $signed({1'b0, frac});
        r2_t0   <= t0;
        r2_side <= r1_side;
        r3_p    <= psum[16:0];
        r3_side <= r2_side;
    end

    assign o_v    = r3_v;
    assign o_p    = r3_p;
    assign o_side = r3_side;

endmodule

// ===== rtl/lrt_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; widths come from the instantiating module.

module lrt_div #(
    parameter int NW = 53,
    parameter int DW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);

    localparam int CTW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [CTW-1:0] r_cnt;
    logic           r_neg;
    logic           r_busy;
    logic           r_done;

    logic [DW:0]    trial;
    logic           take;

    assign trial = {r_rem, r_q[NW-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NW-1];
                r_cnt  <= CTW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[NW-2:0], take};
                r_rem <= take ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// ===== rtl/logistic_regression_trainer_top.sv =====
// Top level: command port, configuration port, epoch sequencer and gradient datapath.
// Depends on lrt_pkg, lrt_mem, lrt_sigm and lrt_div.
//
//   Channel   Direction  Handshake              Payload
//   command   in         start, busy            i_operation, i_x_value, i_y_label, i_batch_last
//   result    out        o_strobe (one cycle)   o_result_kind, o_status, o_weight_out,
//                                               o_bias_out, o_probability, o_class_out
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample that is not the last of a batch is stored when accepted, or dropped if the
// store is full; busy stays low. A prediction holds busy until its result strobes.
// Training of N stored samples repeats for epoch_count epochs: one sample memory read
// per cycle, then the pipeline drains and the serial divider runs twice.
// Reset is synchronous; the model clears to zero and the sample count to zero.
// Results are shown for one cycle and cannot be held off by the receiver.

module logistic_regression_trainer_top #(
    parameter int MAX_SAMPLES     = lrt_pkg::LRT_MAX_SAMPLES,
    parameter int SIGMOID_ENTRIES = lrt_pkg::LRT_SIG_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic signed [31:0] i_x_value,
    input  logic [16:0]        i_y_label,
    input  logic               i_batch_last,
    output logic               o_strobe,
    output logic               o_result_kind,
    output logic               o_status,
    output logic signed [31:0] o_weight_out,
    output logic signed [31:0] o_bias_out,
    output logic [16:0]        o_probability,
    output logic               o_class_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int SWW = 42 + CW;
    localparam int SBW = 18 + CW;
    localparam int MW  = lrt_pkg::X_W + lrt_pkg::Y_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PRED, ST_RUN, ST_DRAIN, ST_DIVW, ST_DIVB, ST_MUL, ST_UPD
    } t_state;

    t_state r_state;

    logic [15:0]         r_lr;
    logic [15:0]         r_epochs;
    logic [16:0]         r_thr;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_acc_n;
    logic [15:0]         r_ep;
    logic                r_full;
    logic signed [31:0]  r_w;
    logic signed [31:0]  r_b;
    logic signed [SWW-1:0] r_sum_w;
    logic signed [SBW-1:0] r_sum_b;
    logic signed [SWW-1:0] r_div_num;
    logic                r_div_go;
    logic signed [41:0]  r_gw;
    logic signed [17:0]  r_gb;
    logic signed [58:0]  r_dwp;
    logic signed [34:0]  r_dbp;

    logic                r_o_strobe;
    logic                r_o_kind;
    logic                r_o_status;
    logic signed [31:0]  r_o_w;
    logic signed [31:0]  r_o_b;
    logic [16:0]         r_o_p;
    logic                r_o_class;

    // datapath pipeline
    logic                r_rdv, r_qv;
    logic signed [31:0]  r_qx;
    logic                r_pa_v, r_pb_v, r_pf_v, r_pg_v;
    logic signed [63:0]  r_pa_prod;
    logic signed [31:0]  r_pa_x, r_pb_x, r_pf_x;
    logic [16:0]         r_pa_y, r_pb_y;
    logic signed [48:0]  r_pb_z;
    logic signed [17:0]  r_pf_e, r_pg_e;
    logic signed [49:0]  r_pg_prod;

    logic                accept;
    logic                is_full;
    logic [16:0]         y_sat;
    logic                mem_we, mem_re;
    logic [MW-1:0]       mem_rdata;
    logic                a_v;
    logic signed [31:0]  a_x;
    logic [16:0]         a_y;
    logic                sg_v;
    logic [16:0]         sg_p;
    logic [MW-1:0]       sg_side;
    logic                train_on;
    logic                dv_done;
    logic signed [SWW-1:0] dv_quot;

    logic signed [59:0]  dw_sum;
    logic signed [35:0]  db_sum;
    logic signed [31:0]  n_w, n_b;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign is_full     = (r_count == CW'(MAX_SAMPLES));
    assign y_sat       = (i_y_label > lrt_pkg::ONE_Q16) ? lrt_pkg::ONE_Q16 : i_y_label;
    assign mem_we      = accept && (i_operation == lrt_pkg::OP_TRAIN) && !is_full;
    assign mem_re      = (r_state == ST_RUN);
    assign o_cfg_ready = 1'b1;
    assign train_on    = (r_state == ST_RUN) || (r_state == ST_DRAIN);

    lrt_mem #(
        .AW (AW),
        .DW (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_x_value, y_sat}),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign a_v = r_rdv || r_qv;
    assign a_x = r_qv ? r_qx : $signed(mem_rdata[MW-1:lrt_pkg::Y_W]);
    assign a_y = mem_rdata[lrt_pkg::Y_W-1:0];

    lrt_sigm #(
        .ENTRIES (SIGMOID_ENTRIES),
        .SW      (MW)
    ) u_sigm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r_pb_v),
        .i_z     (r_pb_z),
        .i_side  ({r_pb_x, r_pb_y}),
        .o_v     (sg_v),
        .o_p     (sg_p),
        .o_side  (sg_side)
    );

    lrt_div #(
        .NW (SWW),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_count),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv  <= 1'b0;
            r_qv   <= 1'b0;
            r_pa_v <= 1'b0;
            r_pb_v <= 1'b0;
            r_pf_v <= 1'b0;
            r_pg_v <= 1'b0;
        end else begin
            r_rdv  <= mem_re;
            r_qv   <= accept && (i_operation == lrt_pkg::OP_PREDICT);
            r_pa_v <= a_v;
            r_pb_v <= r_pa_v;
            r_pf_v <= sg_v && train_on;
            r_pg_v <= r_pf_v;
        end
        r_qx      <= i_x_value;
        r_pa_prod <= r_w * a_x;
        r_pa_x    <= a_x;
        r_pa_y    <= a_y;
        r_pb_z    <= {r_pa_prod[63], r_pa_prod[63:16]} + {{17{r_b[31]}}, r_b};
        r_pb_x    <= r_pa_x;
        r_pb_y    <= r_pa_y;
        r_pf_e    <= $signed({1'b0, sg_p}) - $signed({1'b0, sg_side[lrt_pkg::Y_W-1:0]});
        r_pf_x    <= $signed(sg_side[MW-1:lrt_pkg::Y_W]);
        r_pg_prod <= r_pf_e * r_pf_x;
        r_pg_e    <= r_pf_e;
    end

    // round half up to Q16.16, then subtract with saturation
    assign dw_sum = {r_dwp[58], r_dwp} + 60'sd8388608;
    assign db_sum = {r_dbp[34], r_dbp} + 36'sd32768;
    assign n_w = lrt_pkg::sat32({{8{r_w[31]}}, r_w} - {{4{dw_sum[59]}}, dw_sum[59:24]});
    assign n_b = lrt_pkg::sat32({{8{r_b[31]}}, r_b} - {{20{db_sum[35]}}, db_sum[35:16]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lr       <= lrt_pkg::LR_RESET;
            r_epochs   <= lrt_pkg::EPOCHS_RESET;
            r_thr      <= lrt_pkg::THRESH_RESET;
            r_count    <= '0;
            r_idx      <= '0;
            r_acc_n    <= '0;
            r_ep       <= '0;
            r_full     <= 1'b0;
            r_w        <= '0;
            r_b        <= '0;
            r_div_go   <= 1'b0;
            r_o_strobe <= 1'b0;
            r_o_kind   <= lrt_pkg::KIND_MODEL;
            r_o_status <= lrt_pkg::STAT_OK;
            r_o_w      <= '0;
            r_o_b      <= '0;
            r_o_p      <= '0;
            r_o_class  <= 1'b0;
        end else begin
            r_o_strobe <= 1'b0;
            r_div_go   <= 1'b0;

            if (i_cfg_valid) begin
                case (lrt_pkg::t_cfg_idx'(i_cfg_index))
                    lrt_pkg::CFG_LR:     r_lr     <= i_cfg_data[15:0];
                    lrt_pkg::CFG_EPOCHS: r_epochs <= i_cfg_data[15:0];
                    lrt_pkg::CFG_THRESH: r_thr    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_pg_v) begin
                r_sum_w <= r_sum_w + {{CW{r_pg_prod[49]}}, r_pg_prod[49:8]};
                r_sum_b <= r_sum_b + {{CW{r_pg_e[17]}}, r_pg_e};
                r_acc_n <= r_acc_n + 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_operation == lrt_pkg::OP_PREDICT) begin
                            r_state <= ST_PRED;
                        end else begin
                            if (!is_full) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (i_batch_last) begin
                                r_full <= is_full;
                                if (r_epochs == 16'd0) begin
                                    r_o_strobe <= 1'b1;
                                    r_o_kind   <= lrt_pkg::KIND_MODEL;
                                    r_o_status <= is_full;
                                    r_o_w      <= r_w;
                                    r_o_b      <= r_b;
                                    r_o_p      <= '0;
                                    r_o_class  <= 1'b0;
                                    r_count    <= '0;
                                end else begin
                                    r_state <= ST_RUN;
                                    r_idx   <= '0;
                                    r_ep    <= '0;
                                    r_acc_n <= '0;
                                    r_sum_w <= '0;
                                    r_sum_b <= '0;
                                end
                            end else if (is_full) begin
                                // drop the sample and report the full store
                                r_o_strobe <= 1'b1;
                                r_o_kind   <= lrt_pkg::KIND_MODEL;
                                r_o_status <= lrt_pkg::STAT_FULL;
                                r_o_w      <= r_w;
                                r_o_b      <= r_b;
                                r_o_p      <= '0;
                                r_o_class  <= 1'b0;
                            end
                        end
                    end
                end
                ST_PRED: begin
                    if (sg_v) begin
                        r_o_strobe <= 1'b1;
                        r_o_kind   <= lrt_pkg::KIND_PRED;
                        r_o_status <= lrt_pkg::STAT_OK;
                        r_o_w      <= '0;
                        r_o_b      <= '0;
                        r_o_p      <= sg_p;
                        r_o_class  <= (sg_p >= r_thr);
                        r_state    <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    r_idx <= r_idx + 1'b1;
                    if (CW'(r_idx + 1'b1) == r_count) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_acc_n == r_count) begin
                        r_div_num <= r_sum_w;
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIVW;
                    end
                end
                ST_DIVW: begin
                    if (dv_done) begin
                        r_gw      <= dv_quot[41:0];
                        r_div_num <= {{(SWW - SBW){r_sum_b[SBW-1]}}, r_sum_b};
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIVB;
                    end
                end
                ST_DIVB: begin
                    if (dv_done) begin
                        r_gb    <= dv_quot[17:0];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_dwp   <= $signed({1'b0, r_lr}) * r_gw;
                    r_dbp   <= $signed({1'b0, r_lr}) * r_gb;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_w  <= n_w;
                    r_b  <= n_b;
                    r_ep <= r_ep + 1'b1;
                    if (16'(r_ep + 1'b1) == r_epochs) begin
                        r_o_strobe <= 1'b1;
                        r_o_kind   <= lrt_pkg::KIND_MODEL;
                        r_o_status <= r_full;
                        r_o_w      <= n_w;
                        r_o_b      <= n_b;
                        r_o_p      <= '0;
                        r_o_class  <= 1'b0;
                        r_count    <= '0;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_idx   <= '0;
                        r_acc_n <= '0;
                        r_sum_w <= '0;
                        r_sum_b <= '0;
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_result_kind = r_o_kind;
    assign o_status      = r_o_status;
    assign o_weight_out  = r_o_w;
    assign o_bias_out    = r_o_b;
    assign o_probability = r_o_p;
    assign o_class_out   = r_o_class;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_n <= r_count || r_state == ST_IDLE || r_state == ST_PRED)
        else $error("more samples accumulated than stored");

    a_trained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_kind == lrt_pkg::KIND_MODEL && o_status == lrt_pkg::STAT_OK
        |-> r_count == '0)
        else $error("store not emptied after training");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> r_state == ST_DIVW || r_state == ST_DIVB)
        else $error("divider started outside the divide steps");

    a_no_stray_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sg_v |-> r_state == ST_PRED || r_state == ST_RUN || r_state == ST_DRAIN)
        else $error("sigmoid result with no consumer");

endmodule
